// ===== design/dcm_pkg.sv =====
// Shared types, codes and constants for the DNA complement matcher.
// No dependencies; imported by every module of the block except dcm_checker.
package dcm_pkg;

  // Character codes of the strand alphabet
  localparam logic [7:0] CHAR_A = 8'h41;
  localparam logic [7:0] CHAR_C = 8'h43;
  localparam logic [7:0] CHAR_G = 8'h47;
  localparam logic [7:0] CHAR_T = 8'h54;
  localparam logic [7:0] CHAR_X = 8'h58;

  localparam int unsigned SYM_W = 8;
  localparam int unsigned POS_W = 16;
  localparam int unsigned OFF_W = 16;

  // Input item kind carried on tuser
  typedef enum logic {
    OP_PROBE  = 1'b0,
    OP_TARGET = 1'b1
  } dcm_op_e;

  // Shift strobes broadcast to the row of cells
  typedef struct packed {
    logic shift_tgt;
    logic shift_prb;
  } dcm_ctrl_t;

  // One result transaction
  typedef struct packed {
    logic             found;
    logic [POS_W-1:0] position;
  } dcm_result_t;

  // Watson-Crick complement; anything outside the alphabet maps to X
  function automatic logic [SYM_W-1:0] complement_of(input logic [SYM_W-1:0] b);
    logic [SYM_W-1:0] r;
    case (b)
      CHAR_A:  r = CHAR_T;
      CHAR_T:  r = CHAR_A;
      CHAR_C:  r = CHAR_G;
      CHAR_G:  r = CHAR_C;
      default: r = CHAR_X;
    endcase
    return r;
  endfunction

endpackage

// ===== design/dcm_cell.sv =====
// One cell of the compare row: holds a probe byte, its valid bit and a target tap.
// Depends on dcm_pkg for the control struct.
module dcm_cell (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  dcm_pkg::dcm_ctrl_t       ctrl_i,
  input  logic [dcm_pkg::SYM_W-1:0] tgt_i,
  input  logic [dcm_pkg::SYM_W-1:0] prb_i,
  input  logic                     pvalid_i,
  output logic [dcm_pkg::SYM_W-1:0] tgt_o,
  output logic [dcm_pkg::SYM_W-1:0] prb_o,
  output logic                     pvalid_o,
  output logic                     ok_o
);
  import dcm_pkg::*;

  logic [SYM_W-1:0] tgt_q;
  logic [SYM_W-1:0] prb_q;
  logic             pvalid_q;

  // Probe valid bit: shift along with the probe bytes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pvalid_q <= 1'b0;
    end else if (ctrl_i.shift_prb) begin
      pvalid_q <= pvalid_i;
    end
  end

  // Payload bytes: advance from the neighbor
  always_ff @(posedge clk_i) begin
    if (ctrl_i.shift_prb) begin
      prb_q <= prb_i;
    end
    if (ctrl_i.shift_tgt) begin
      tgt_q <= tgt_i;
    end
  end

  // Compare the byte about to land here against the held probe byte
  assign ok_o     = !pvalid_q || (tgt_i == prb_q);
  assign tgt_o    = tgt_q;
  assign prb_o    = prb_q;
  assign pvalid_o = pvalid_q;

endmodule

// ===== design/dcm_out_skid.sv =====
// Output register with a skid stage for result transactions.
// Depends on dcm_pkg for the result struct.
module dcm_out_skid (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  dcm_pkg::dcm_result_t  data_i,
  output logic                  ready_o,
  output logic                  valid_o,
  input  logic                  ready_i,
  output dcm_pkg::dcm_result_t  data_o
);
  import dcm_pkg::*;

  logic        out_valid_q;
  logic        skid_valid_q;
  dcm_result_t out_q;
  dcm_result_t skid_q;
  logic        pop;
  logic        load_out;

  assign pop      = out_valid_q && ready_i;
  assign load_out = !out_valid_q || pop;

  // Valid flags: refill the output from the skid first
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q  <= skid_valid_q || push_i;
      skid_valid_q <= 1'b0;
    end else if (push_i) begin
      skid_valid_q <= 1'b1;
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_q <= skid_valid_q ? skid_q : data_i;
    end else if (push_i) begin
      skid_q <= data_i;
    end
  end

  assign ready_o = !skid_valid_q;
  assign valid_o = out_valid_q;
  assign data_o  = out_q;

endmodule

// ===== design/dna_complement_matcher.sv =====
// A result is registered in the output stage, or in the skid stage while the output is stalled, before it leaves.
// Throughput: one byte (probe or target) per cycle; the whole window is compared in parallel
// across the row of cells, and s_axis_tready drops only while both output stages are full.
// Reset (rst_ni low, asynchronous): probe length, probe valid bits, target count, flags and
// start_offset clear at once; probe and window bytes are unset until written, no clearing pass.
module dna_complement_matcher #(
  parameter int unsigned MAX_PROBE  = 32,
  parameter int unsigned MAX_TARGET = 65536
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // Configuration: start_offset
  input  logic                       cfg_we_i,
  input  logic [dcm_pkg::OFF_W-1:0]  cfg_wdata_i,
  // Input stream
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  input  logic [7:0]                 s_axis_tdata,   // [7:0] symbol
  input  logic                       s_axis_tlast,   // last byte of probe or target
  input  logic                       s_axis_tuser,   // [0] opcode
  // Result stream
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  output logic [15:0]                m_axis_tdata,   // [15:0] position
  output logic                       m_axis_tuser    // [0] found
);
  import dcm_pkg::*;

  localparam int unsigned LW  = $clog2(MAX_PROBE + 1);
  localparam int unsigned CW  = $clog2(MAX_TARGET + 1);
  localparam int unsigned CW1 = (CW > LW) ? CW : LW;
  localparam int unsigned XW  = (CW1 > OFF_W) ? CW1 : OFF_W;

  logic [OFF_W-1:0] off_q;
  logic [LW-1:0]    len_q, len_d;
  logic             closed_q, closed_d;
  logic [CW-1:0]    count_q, count_d;
  logic             done_q, done_d;

  logic             s_acc, prb_acc, tgt_acc, restart;
  logic [CW-1:0]    count_inc;
  logic [XW-1:0]    begin_w;
  logic             hit, push;
  dcm_ctrl_t        ctrl;
  dcm_result_t      res;
  dcm_result_t      res_out;

  logic [SYM_W-1:0] tgt_w   [MAX_PROBE];
  logic [SYM_W-1:0] prb_w   [MAX_PROBE];
  logic             pv_w    [MAX_PROBE];
  logic [MAX_PROBE-1:0] ok_w;

  assign s_acc   = s_axis_tvalid && s_axis_tready;
  assign prb_acc = s_acc && (dcm_op_e'(s_axis_tuser) == OP_PROBE);
  assign tgt_acc = s_acc && (dcm_op_e'(s_axis_tuser) == OP_TARGET);
  assign restart = prb_acc && closed_q;

  // Shift strobes for the cell row
  always_comb begin
    ctrl.shift_prb = prb_acc && (restart || (len_q < LW'(MAX_PROBE)));
    ctrl.shift_tgt = tgt_acc && (count_q < CW'(MAX_TARGET));
  end

  // Row of cells: newest byte enters cell 0
  for (genvar k = 0; k < MAX_PROBE; k++) begin : g_cell
    logic [SYM_W-1:0] tgt_in, prb_in;
    logic             pv_in;
    if (k == 0) begin : g_head
      assign tgt_in = s_axis_tdata;
      assign prb_in = complement_of(s_axis_tdata);
      assign pv_in  = 1'b1;
    end else begin : g_body
      assign tgt_in = tgt_w[k-1];
      assign prb_in = prb_w[k-1];
      assign pv_in  = pv_w[k-1] && !restart;
    end
    dcm_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctrl_i   (ctrl),
      .tgt_i    (tgt_in),
      .prb_i    (prb_in),
      .pvalid_i (pv_in),
      .tgt_o    (tgt_w[k]),
      .prb_o    (prb_w[k]),
      .pvalid_o (pv_w[k]),
      .ok_o     (ok_w[k])
    );
  end

  // Match decision for the window that the current byte completes
  assign count_inc = count_q + CW'(1);
  assign begin_w   = XW'(count_inc) - XW'(len_q);
  assign hit = ctrl.shift_tgt && !done_q && pv_w[0]
            && (XW'(count_inc) >= XW'(len_q))
            && (begin_w >= XW'(off_q))
            && (&ok_w);

  assign push = hit || (tgt_acc && s_axis_tlast && !done_q);

  always_comb begin
    res.found    = hit;
    res.position = hit ? begin_w[POS_W-1:0] : '0;
  end

  // Next state of probe and target bookkeeping
  always_comb begin
    len_d    = len_q;
    closed_d = closed_q;
    count_d  = count_q;
    done_d   = done_q;
    if (prb_acc) begin
      closed_d = s_axis_tlast;
      if (restart) begin
        len_d   = LW'(1);
        count_d = '0;
        done_d  = 1'b0;
      end else if (ctrl.shift_prb) begin
        len_d = len_q + LW'(1);
      end
    end else if (tgt_acc) begin
      closed_d = 1'b1;
      if (s_axis_tlast) begin
        count_d = '0;
        done_d  = 1'b0;
      end else if (ctrl.shift_tgt) begin
        count_d = count_inc;
        done_d  = done_q || hit;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      off_q    <= '0;
      len_q    <= '0;
      closed_q <= 1'b0;
      count_q  <= '0;
      done_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        off_q <= cfg_wdata_i;
      end
      len_q    <= len_d;
      closed_q <= closed_d;
      count_q  <= count_d;
      done_q   <= done_d;
    end
  end

  // Result register and skid
  dcm_out_skid u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (res),
    .ready_o (s_axis_tready),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .data_o  (res_out)
  );

  assign m_axis_tuser = res_out.found;
  assign m_axis_tdata = res_out.position;

endmodule

// ===== design/dcm_checker.sv =====
// Port-level checks for dna_complement_matcher, attached by bind.
// Depends only on the top level's ports.
module dcm_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        s_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata,
  input logic        m_axis_tuser
);

  // A not-found result carries position zero
  a_nf_pos_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata == 16'd0))
    else $error("not-found result with nonzero position");

  // Backpressure on input only while a result is held
  a_ready_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid)
    else $error("input stalled with empty output");

  // A probe byte into an empty output creates no result
  a_probe_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && !s_axis_tuser && !m_axis_tvalid) |=> !m_axis_tvalid)
    else $error("probe byte produced a result");

  // Stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
    else $error("stalled result changed");

endmodule

bind dna_complement_matcher dcm_checker u_dcm_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
